/* design/wspd_pkg.sv */
package wspd_pkg;

    localparam int FRAME_BYTES_DEF = 12;
    localparam int OVERHEAD_BYTES  = 3;
    localparam int LEFT_AT         = 3;
    localparam int RIGHT_AT        = 7;
    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_start;
    } wspd_in_t;

    typedef struct packed {
        logic signed [31:0] left_target;
        logic signed [31:0] right_target;
    } wspd_out_t;

    // per-cell control: shift is shared by every cell of the window, clear differs for the newest cell
    typedef struct packed {
        logic shift;
        logic clear;
    } wspd_cell_ctl_t;

endpackage

/* design/wspd_cell.sv */
module wspd_cell
    import wspd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  wspd_cell_ctl_t ctl,
    input  logic [7:0]     byte_in,
    input  logic           valid_in,
    output logic [7:0]     byte_out,
    output logic           valid_out
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       valid_reg;
    logic       valid_next;

    always_comb
    begin
        byte_next  = byte_reg;
        valid_next = valid_reg;
        if (ctl.shift)
        begin
            byte_next  = byte_in;
            valid_next = valid_in && !ctl.clear;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

/* design/wspd_check.sv */
module wspd_check
    import wspd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic [7:0] win [FRAME_BYTES],
    input  logic       full,
    output logic       hit,
    output wspd_out_t  res
);

    logic [7:0] sum;

    // XOR over the length byte and both speeds
    always_comb
    begin
        sum = 8'h00;
        for (int i = 2; i < FRAME_BYTES - 1; i++)
        begin
            sum = sum ^ win[i];
        end
    end

    assign hit = full
              && (win[0] == SYNC_FIRST)
              && (win[1] == SYNC_SECOND)
              && (win[2] == 8'(FRAME_BYTES - OVERHEAD_BYTES))
              && (sum == win[FRAME_BYTES-1]);

    assign res.left_target  = {win[LEFT_AT], win[LEFT_AT+1], win[LEFT_AT+2], win[LEFT_AT+3]};
    assign res.right_target = {win[RIGHT_AT], win[RIGHT_AT+1], win[RIGHT_AT+2],
                               win[RIGHT_AT+3]};

endmodule

/* design/wspd_out_buf.sv */
module wspd_out_buf
    import wspd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  wspd_out_t push_res,
    output logic      skid_full,
    output logic      out_valid,
    input  logic      out_ready,
    output wspd_out_t out_res
);

    logic      main_valid_reg;
    logic      main_valid_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    wspd_out_t main_reg;
    wspd_out_t main_next;
    wspd_out_t skid_reg;
    wspd_out_t skid_next;
    logic      pop;

    assign pop = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg && !pop;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign skid_full = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

endmodule

/* design/wheel_speed_packet_deframer.sv */
// Wheel speed packet deframer.
// Input channel (in_valid/in_ready/in_req): one received byte per request,
// with buffer_start marking the first byte of a new receive buffer; the
// bytes held so far are dropped before that byte is taken.
// Output channel (out_valid/out_ready/out_res): one request per valid frame,
// carrying the signed left and right speeds decoded big-endian.
// A frame is AA 55, length 9, eight speed bytes, then the XOR of the nine
// bytes from the length on. Every byte position is tried as a frame start;
// after a good frame the window empties, so frames never overlap.
// Throughput: one byte per cycle while in_ready is high. The frame test looks
// at the window as it will be after the byte is shifted in, so a result is
// registered into the output buffer at the accepting edge of its last byte.
// Reset empties the window and the output buffer; nothing is pending.
// Stall: the output has a result register plus one skid entry. in_ready
// drops only while the skid entry is occupied, so bytes keep flowing while a
// single result waits on the receiver.
module wheel_speed_packet_deframer
    import wspd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  wspd_in_t  in_req,
    output logic      out_valid,
    input  logic      out_ready,
    output wspd_out_t out_res
);

    logic [7:0]       win_cur  [FRAME_BYTES];
    logic [7:0]       win_next [FRAME_BYTES];
    logic [FRAME_BYTES-1:0] valid_vec;
    logic             accept;
    logic             full_next;
    logic             hit;
    logic             skid_full;
    wspd_out_t        frame_res;

    assign accept = in_valid && in_ready;
    assign in_ready = !skid_full;

    // Window as it stands after this byte: slide toward cell 0, new byte last.
    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES - 1; i++)
        begin
            win_next[i] = win_cur[i+1];
        end
        win_next[FRAME_BYTES-1] = in_req.rx_byte;
    end

    // Full once the oldest slot holds a byte of the current buffer.
    assign full_next = valid_vec[1] && !in_req.buffer_start;

    wspd_check #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_check (
        .win  (win_next),
        .full (full_next),
        .hit  (hit),
        .res  (frame_res)
    );

    // Cell 0 holds the oldest byte. A buffer start clears all but the newest
    // cell; a good frame clears every cell.
    genvar g;
    generate
        for (g = 0; g < FRAME_BYTES; g++)
        begin : g_cell
            wspd_cell_ctl_t ctl;
            logic [7:0]     byte_in;
            logic           valid_in;

            if (g == FRAME_BYTES - 1)
            begin : g_last
                assign byte_in   = in_req.rx_byte;
                assign valid_in  = 1'b1;
                assign ctl.clear = hit;
            end
            else
            begin : g_mid
                assign byte_in   = win_cur[g+1];
                assign valid_in  = valid_vec[g+1];
                assign ctl.clear = hit || in_req.buffer_start;
            end
            assign ctl.shift = accept;

            wspd_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .byte_in   (byte_in),
                .valid_in  (valid_in),
                .byte_out  (win_cur[g]),
                .valid_out (valid_vec[g])
            );
        end
    endgenerate

    wspd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && hit),
        .push_res  (frame_res),
        .skid_full (skid_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    // A buffer start leaves exactly the new byte in the window.
    a_buf_start_one: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_req.buffer_start) |=> ($countones(valid_vec) == 1))
        else $error("window not restarted on buffer start");

    // A good frame empties the window.
    a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && hit) |=> (valid_vec == '0))
        else $error("window not emptied after frame");

    // A good frame always yields a pending result.
    a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && hit) |=> out_valid)
        else $error("frame result lost");

    // The skid entry is used only behind a waiting result.
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full |-> out_valid)
        else $error("skid entry held with output empty");

    // A frame test never fires on a partly filled window.
    a_hit_full: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> (valid_vec[1] && !in_req.buffer_start))
        else $error("frame detected in partial window");

endmodule

/* sim/tb_wheel_speed_packet_deframer.sv */
`timescale 1ns / 1ps

module tb_wheel_speed_packet_deframer;
    import wspd_pkg::*;

    // Ways a generated frame can be spoiled on purpose
    typedef enum int {
        FLAW_NONE,
        FLAW_HEADER,
        FLAW_LENGTH,
        FLAW_CHECKSUM
    } frame_flaw_e;

    localparam int CLK_HALF  = 6;
    localparam int NO_BS     = -1;   // no buffer_start inside the frame
    localparam int PHASE_LEN = 212;  // bytes of random traffic per idling phase

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    wspd_in_t  in_req    = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    wspd_out_t out_res;

    // Bytes waiting to be offered, and speed pairs the deframer owes us
    wspd_in_t  rx_pending[$];
    wspd_out_t speeds_due[$];

    // Shadow of the deframer's byte window
    logic [7:0] win_bytes[FRAME_BYTES_DEF];
    int         win_fill = 0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          err_count      = 0;

    wheel_speed_packet_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the handshake locks up
    initial
    begin
        #(2 * CLK_HALF * 300_000);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Take one accepted byte into the shadow window; a good frame yields
    // one speed pair and empties the window.
    function void scan_rx_byte(input wspd_in_t req);
        logic [7:0] sum;
        wspd_out_t  pair;
        if (req.buffer_start)
            win_fill = 0;
        if (win_fill < FRAME_BYTES_DEF)
        begin
            win_bytes[win_fill] = req.rx_byte;
            win_fill++;
        end
        else
        begin
            for (int i = 0; i < FRAME_BYTES_DEF - 1; i++)
                win_bytes[i] = win_bytes[i + 1];
            win_bytes[FRAME_BYTES_DEF - 1] = req.rx_byte;
        end
        if (win_fill == FRAME_BYTES_DEF && win_bytes[0] == SYNC_FIRST &&
            win_bytes[1] == SYNC_SECOND &&
            win_bytes[2] == 8'(FRAME_BYTES_DEF - OVERHEAD_BYTES))
        begin
            sum = '0;
            for (int i = 2; i < FRAME_BYTES_DEF - 1; i++)
                sum ^= win_bytes[i];
            if (sum == win_bytes[FRAME_BYTES_DEF - 1])
            begin
                pair.left_target  = {win_bytes[LEFT_AT], win_bytes[LEFT_AT + 1],
                                     win_bytes[LEFT_AT + 2], win_bytes[LEFT_AT + 3]};
                pair.right_target = {win_bytes[RIGHT_AT], win_bytes[RIGHT_AT + 1],
                                     win_bytes[RIGHT_AT + 2], win_bytes[RIGHT_AT + 3]};
                speeds_due.push_back(pair);
                win_fill = 0;
            end
        end
    endfunction

    function void queue_byte(input logic [7:0] b, input logic bs);
        wspd_in_t req;
        req.rx_byte      = b;
        req.buffer_start = bs;
        rx_pending.push_back(req);
    endfunction

    // Queue the first `keep` bytes of a frame; buffer_start goes on byte
    // `bs_at` (NO_BS for none).
    function void queue_frame(input logic [31:0] left, input logic [31:0] right,
                              input frame_flaw_e flaw, input int keep, input int bs_at);
        logic [7:0] fb[FRAME_BYTES_DEF];
        fb[0] = SYNC_FIRST;
        fb[1] = SYNC_SECOND;
        fb[2] = 8'(FRAME_BYTES_DEF - OVERHEAD_BYTES);
        for (int i = 0; i < 4; i++)
        begin
            fb[LEFT_AT + i]  = 8'(left >> (24 - 8 * i));
            fb[RIGHT_AT + i] = 8'(right >> (24 - 8 * i));
        end
        fb[FRAME_BYTES_DEF - 1] = '0;
        for (int i = 2; i < FRAME_BYTES_DEF - 1; i++)
            fb[FRAME_BYTES_DEF - 1] ^= fb[i];
        case (flaw)
            FLAW_HEADER:   fb[$urandom_range(1)] ^= 8'($urandom_range(1, 255));
            FLAW_LENGTH:   fb[2] ^= 8'($urandom_range(1, 255));
            FLAW_CHECKSUM: fb[FRAME_BYTES_DEF - 1] ^= 8'($urandom_range(1, 255));
            default:       ;
        endcase
        for (int i = 0; i < keep; i++)
            queue_byte(fb[i], i == bs_at);
    endfunction

    // Speeds lean on the signed extremes now and then
    function logic [31:0] pick_speed();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Sender: a byte is offered while in_valid is low or just taken.
    // The accepted byte goes through the shadow window on its accepting edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_req   <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                scan_rx_byte(in_req);
            if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_req   <= rx_pending.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, each taken result checked against the oldest
    // speed pair owed.
    always @(posedge clk or negedge rst_n)
    begin
        wspd_out_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (speeds_due.size() == 0)
                    note_error($sformatf("result with none owed: left %0d right %0d",
                                         out_res.left_target, out_res.right_target));
                else
                begin
                    want = speeds_due.pop_front();
                    if (out_res.left_target !== want.left_target)
                        note_error($sformatf("left_target exp %0d got %0d",
                                             want.left_target, out_res.left_target));
                    if (out_res.right_target !== want.right_target)
                        note_error($sformatf("right_target exp %0d got %0d",
                                             want.right_target, out_res.right_target));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int unsigned send_pct[4];
        int unsigned stall_pct[4];
        int          start_len;
        int          pick;

        // idling phases: none, sender, receiver, both
        send_pct  = '{0, 60, 0, 25};
        stall_pct = '{0, 0, 60, 25};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: a stray sync byte before a frame with the signed extremes
        // (window fills, then slides by one onto the frame), then a partial
        // frame cut off by a buffer start that opens a good frame.
        queue_byte(SYNC_FIRST, 1'b0);
        queue_frame(32'h8000_0000, 32'h7FFF_FFFF, FLAW_NONE, FRAME_BYTES_DEF, NO_BS);
        queue_frame(32'h0000_0000, 32'h0000_0000, FLAW_NONE, 5, NO_BS);
        queue_frame(32'hFFFF_FFFF, 32'h0000_0000, FLAW_NONE, FRAME_BYTES_DEF, 0);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = stall_pct[ph];
            start_len      = rx_pending.size();
            // Mostly good frames with random speeds; the rest is spoiled,
            // cut short, split by a buffer start, or plain line noise.
            while (rx_pending.size() - start_len < PHASE_LEN)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    queue_frame(pick_speed(), pick_speed(), FLAW_NONE, FRAME_BYTES_DEF,
                                ($urandom_range(3) == 0) ? 0 : NO_BS);
                else if (pick < 70)
                    queue_frame(pick_speed(), pick_speed(),
                                frame_flaw_e'($urandom_range(FLAW_HEADER, FLAW_CHECKSUM)),
                                FRAME_BYTES_DEF, NO_BS);
                else if (pick < 80)
                    queue_frame(pick_speed(), pick_speed(), FLAW_NONE,
                                $urandom_range(1, FRAME_BYTES_DEF - 1), NO_BS);
                else if (pick < 90)
                    repeat ($urandom_range(1, 6))
                        queue_byte(($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom()),
                                   ($urandom_range(7) == 0));
                else
                    queue_frame(pick_speed(), pick_speed(), FLAW_NONE, FRAME_BYTES_DEF,
                                $urandom_range(1, FRAME_BYTES_DEF - 1));
            end
            // Hold off new bytes until the deframer has paid out everything
            while (rx_pending.size() != 0 || in_valid)
                @(posedge clk);
            while (speeds_due.size() != 0)
                @(posedge clk);
        end

        // Drain: give any late result time to show up
        repeat (20) @(posedge clk);
        if (speeds_due.size() != 0)
            note_error($sformatf("%0d results never arrived", speeds_due.size()));
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
design/wspd_pkg.sv
design/wspd_cell.sv
design/wspd_check.sv
design/wspd_out_buf.sv
design/wheel_speed_packet_deframer.sv
sim/tb_wheel_speed_packet_deframer.sv
